>>> hw/rtl/ckt_pkg.sv
// counted key table: shared types, sizes and helpers
// used by ckt_engine, counted_key_table and the bench; no dependencies
package ckt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int NUM_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 40;
    localparam int ENTRY_W  = KEY_W + CNT_W;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 120;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_ERASE_ONE = 3'd1,
        OP_ERASE_ALL = 3'd2,
        OP_COUNT     = 3'd3,
        OP_GET       = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_GET_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SUM_W-1:0] total_items;
        logic [NUM_W-1:0] distinct_entries;
        logic [KEY_W-1:0] key_out;
        logic [CNT_W-1:0] occurrences;
        logic             found;
        t_status          status;
    } t_result;

    function automatic logic [SUM_W-1:0] sum_inc(input logic [SUM_W-1:0] s);
        return (s == SUM_MAX) ? s : s + SUM_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] sum_sub(input logic [SUM_W-1:0] s,
                                                 input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] n_ext;
        n_ext = SUM_W'(n);
        return (s > n_ext) ? s - n_ext : '0;
    endfunction

endpackage

>>> hw/rtl/ckt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ckt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ckt_engine.sv
// counted key table sequencer: linear search, update, shift-down and get
// over the entry ram; holds the entry count and occurrence total. uses ckt_pkg
module ckt_engine
    import ckt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [7:0]         i_pos,
    output logic               o_we,
    output logic [IDX_W-1:0]   o_waddr,
    output logic [ENTRY_W-1:0] o_wdata,
    output logic [IDX_W-1:0]   o_raddr,
    input  logic [ENTRY_W-1:0] i_rdata,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_result            o_res
);

    t_state           r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [NUM_W-1:0] r_ia, n_ia;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic [NUM_W-1:0] r_total, n_total;
    logic [SUM_W-1:0] r_sum, n_sum;
    t_status          r_status, n_status;
    logic             r_found, n_found;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [KEY_W-1:0] r_kout, n_kout;

    logic [KEY_W-1:0] rd_key;
    logic [CNT_W-1:0] rd_cnt;
    logic             hit;
    logic             scan_end;

    assign rd_key   = i_rdata[ENTRY_W-1:CNT_W];
    assign rd_cnt   = i_rdata[CNT_W-1:0];
    // the one shared compare: stored key against the requested key
    assign hit      = r_pend && (rd_key == r_key);
    assign scan_end = !r_pend && (r_ia >= r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_total <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_total <= n_total;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_ia     <= n_ia;
        r_pidx   <= n_pidx;
        r_status <= n_status;
        r_found  <= n_found;
        r_occ    <= n_occ;
        r_kout   <= n_kout;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_ia     = r_ia;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_total  = r_total;
        n_sum    = r_sum;
        n_status = r_status;
        n_found  = r_found;
        n_occ    = r_occ;
        n_kout   = r_kout;
        o_we     = 1'b0;
        o_waddr  = r_pidx;
        o_wdata  = i_rdata;
        o_raddr  = r_ia[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_op;
                    n_key    = i_key;
                    n_ia     = '0;
                    n_pend   = 1'b0;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_occ    = '0;
                    n_kout   = '0;
                    o_raddr  = i_pos[IDX_W-1:0];
                    priority if (i_op == OP_INSERT && r_total == NUM_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else if (i_op == OP_INSERT || i_op == OP_ERASE_ONE ||
                                 i_op == OP_ERASE_ALL || i_op == OP_COUNT) begin
                        n_state = S_SEARCH;
                    end else if (i_op == OP_GET) begin
                        if (NUM_W'(i_pos) >= r_total) begin
                            n_status = ST_BAD_POS;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_GET_WAIT;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_SEARCH: begin
                // one read issued per cycle, compared the cycle after
                if (r_ia < r_total) begin
                    n_ia   = r_ia + NUM_W'(1);
                    n_pend = 1'b1;
                    n_pidx = r_ia[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_pend  = 1'b0;
                    n_ia    = NUM_W'(r_pidx) + NUM_W'(1);
                    n_state = S_DONE;
                    o_waddr = r_pidx;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (rd_cnt != CNT_MAX) begin
                                o_we    = 1'b1;
                                o_wdata = {rd_key, rd_cnt + CNT_W'(1)};
                                n_occ   = rd_cnt + CNT_W'(1);
                                n_sum   = sum_inc(r_sum);
                            end else begin
                                n_occ = rd_cnt;
                            end
                        end
                        OP_ERASE_ONE: begin
                            n_occ = CNT_W'(1);
                            n_sum = sum_sub(r_sum, CNT_W'(1));
                            if (rd_cnt > CNT_W'(1)) begin
                                o_we    = 1'b1;
                                o_wdata = {rd_key, rd_cnt - CNT_W'(1)};
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        OP_ERASE_ALL: begin
                            n_occ   = rd_cnt;
                            n_sum   = sum_sub(r_sum, rd_cnt);
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_occ = rd_cnt;
                        end
                    endcase
                end else if (scan_end) begin
                    n_state = S_DONE;
                    if (r_op == OP_INSERT) begin
                        // new key goes to the end of the table
                        o_we    = 1'b1;
                        o_waddr = r_total[IDX_W-1:0];
                        o_wdata = {r_key, CNT_W'(1)};
                        n_total = r_total + NUM_W'(1);
                        n_sum   = sum_inc(r_sum);
                        n_occ   = CNT_W'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT: begin
                // read entry i+1, write it to i the cycle after
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_pidx - IDX_W'(1);
                    o_wdata = i_rdata;
                end
                if (r_ia < r_total) begin
                    n_ia   = r_ia + NUM_W'(1);
                    n_pend = 1'b1;
                    n_pidx = r_ia[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (scan_end) begin
                    n_total = r_total - NUM_W'(1);
                    n_state = S_DONE;
                end
            end

            S_GET_WAIT: begin
                n_found = 1'b1;
                n_occ   = rd_cnt;
                n_kout  = rd_key;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status           = r_status;
        o_res.found            = r_found;
        o_res.occurrences      = r_occ;
        o_res.key_out          = r_kout;
        o_res.distinct_entries = r_total;
        o_res.total_items      = r_sum;
    end

endmodule

>>> hw/rtl/counted_key_table.sv
// counted key table top level: entry ram, sequencer and output register
// depends on ckt_pkg, ckt_ram and ckt_engine
//
//  channel  | dir | handshake              | tdata fields, lowest bit first
//  slave    | in  | i_s_tvalid/o_s_tready  | op, key, position
//  master   | out | o_m_tvalid/i_m_tready  | status, found, occurrences, key_out,
//           |     |                        | distinct_entries, total_items
//
// one word at a time; the table is scanned one entry a cycle through the
// single ram read port, and an erase that removes an entry then shifts the
// later entries down one place.
// synchronous active-low reset clears the counts; no ram clearing pass.
// a stalled output word holds in its register; the next word is taken
// once the result has moved into that register.
module counted_key_table
    import ckt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // op[2:0], key[34:3], position[42:35]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // status[1:0], found[2], occurrences[34:3],
                                          // key_out[66:35], distinct_entries[75:67],
                                          // total_items[115:76]
);

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
    logic [ENTRY_W-1:0] rdata;
    logic               res_valid;
    logic               res_take;
    t_result            res;
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;

    ckt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ckt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_op        (i_s_tdata[2:0]),
        .i_key       (i_s_tdata[34:3]),
        .i_pos       (i_s_tdata[42:35]),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign res_take = res_valid && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_data <= {(OUT_W - $bits(t_result))'(0), res};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // table never holds more than its capacity
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[75:67] <= NUM_W'(CAPACITY)))
        else $error("distinct entry count beyond capacity");

    // one word at a time: not ready in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while busy");

    // a miss or refusal never reports a hit or a count
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] != 2'(ST_OK))) |->
            (!o_m_tdata[2] && (o_m_tdata[34:3] == '0) && (o_m_tdata[66:35] == '0)))
        else $error("failed operation carries data");

endmodule

>>> bench/tb.sv
// self-checking bench for counted_key_table: directed table, then random words
// checked against a behavioural copy of the key table; depends on ckt_pkg and counted_key_table
module tb;
    import ckt_pkg::*;

    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 600;
    localparam int POOL_NARROW    = 8;
    localparam int POOL_WIDE      = 40;

    typedef struct packed {
        logic [2:0]       op;
        logic [KEY_W-1:0] key;
        logic [7:0]       pos;
        logic             typed;
        t_result          res;
    } t_row;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata  = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    // behavioural copy of the table
    logic [KEY_W-1:0] tbl_keys   [CAPACITY];
    logic [CNT_W-1:0] tbl_counts [CAPACITY];
    int               tbl_used = 0;
    logic [SUM_W-1:0] tbl_sum  = '0;

    t_result          expected_results [$];
    t_row             rows [$];
    logic [KEY_W-1:0] key_pool [POOL_WIDE];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  words_sent   = 0;
    int  gap_rate     = 0;
    bit  calm         = 1'b0;
    bit  held         = 1'b0;

    counted_key_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // applies one operation to the table copy and returns the word it should produce
    function automatic t_result table_apply(input logic [2:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input logic [7:0] pos);
        t_result r;
        int      hit;
        int      i;
        r   = '0;
        hit = -1;
        for (i = 0; i < tbl_used; i++) begin
            if (hit < 0 && tbl_keys[i] == key) hit = i;
        end
        case (op)
            OP_INSERT: begin
                if (tbl_used >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (hit >= 0) begin
                    r.found = 1'b1;
                    if (tbl_counts[hit] != CNT_MAX) begin
                        tbl_counts[hit] = tbl_counts[hit] + CNT_W'(1);
                        if (tbl_sum != SUM_MAX) tbl_sum = tbl_sum + SUM_W'(1);
                    end
                    r.occurrences = tbl_counts[hit];
                end else begin
                    tbl_keys[tbl_used]   = key;
                    tbl_counts[tbl_used] = 1;
                    tbl_used++;
                    if (tbl_sum != SUM_MAX) tbl_sum = tbl_sum + SUM_W'(1);
                    r.occurrences = 1;
                end
            end
            OP_ERASE_ONE, OP_ERASE_ALL: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    r.occurrences = (op == OP_ERASE_ONE) ? CNT_W'(1) : tbl_counts[hit];
                    tbl_sum = (tbl_sum > SUM_W'(r.occurrences)) ?
                              tbl_sum - SUM_W'(r.occurrences) : '0;
                    if (op == OP_ERASE_ONE && tbl_counts[hit] != 0)
                        tbl_counts[hit] = tbl_counts[hit] - CNT_W'(1);
                    // entry goes when its count runs out; later entries close the gap
                    if (op == OP_ERASE_ALL || tbl_counts[hit] == 0) begin
                        for (i = hit; i + 1 < tbl_used; i++) begin
                            tbl_keys[i]   = tbl_keys[i + 1];
                            tbl_counts[i] = tbl_counts[i + 1];
                        end
                        tbl_used--;
                    end
                end
            end
            OP_COUNT: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found       = 1'b1;
                    r.occurrences = tbl_counts[hit];
                end
            end
            OP_GET: begin
                if (int'(pos) >= tbl_used) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.found       = 1'b1;
                    r.occurrences = tbl_counts[pos];
                    r.key_out     = tbl_keys[pos];
                end
            end
            default: ;
        endcase
        r.distinct_entries = NUM_W'(tbl_used);
        r.total_items      = tbl_sum;
        return r;
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [KEY_W-1:0] key,
                             input logic [7:0] pos, input logic typed,
                             input t_result typed_res);
        t_result pred;
        if (words_sent % 40 == 0) begin
            case ($urandom_range(0, 2))
                0: gap_rate = 0;
                1: gap_rate = 3;
                default: gap_rate = 15;
            endcase
        end
        words_sent++;
        @(negedge i_clk);
        if (!calm && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, pos, key, op};
        do @(posedge i_clk); while (!o_s_tready);
        pred = table_apply(op, key, pos);
        expected_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic random_word(input int pool_n);
        int               w;
        logic [2:0]       op;
        logic [KEY_W-1:0] key;
        logic [7:0]       pos;
        w = $urandom_range(0, 99);
        if (w < 40)      op = OP_INSERT;
        else if (w < 55) op = OP_ERASE_ONE;
        else if (w < 63) op = OP_ERASE_ALL;
        else if (w < 78) op = OP_COUNT;
        else if (w < 95) op = OP_GET;
        else             op = OP_RSVD_A + 3'($urandom_range(0, 2));
        w = $urandom_range(0, 9);
        if (w < 4 && tbl_used > 0) key = tbl_keys[$urandom_range(0, tbl_used - 1)];
        else if (w < 9)            key = key_pool[$urandom_range(0, pool_n - 1)];
        else                       key = $urandom;
        // mostly around the filled part, including one past the end
        if ($urandom_range(0, 3) == 0) pos = 8'($urandom_range(0, 255));
        else pos = 8'($urandom_range(0, (tbl_used > 255) ? 255 : tbl_used));
        send_word(op, key, pos, 1'b0, '0);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [KEY_W-1:0] key,
                           input logic [7:0] pos, input int typed,
                           input t_status st, input int fnd,
                           input int occ, input int kout,
                           input int n_used, input int sum);
        t_row row;
        row.op  = op;
        row.key = key;
        row.pos = pos;
        row.typed = (typed != 0);
        row.res.status           = st;
        row.res.found            = (fnd != 0);
        row.res.occurrences      = CNT_W'(occ);
        row.res.key_out          = KEY_W'(kout);
        row.res.distinct_entries = NUM_W'(n_used);
        row.res.total_items      = SUM_W'(sum);
        rows.push_back(row);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: st=%0d f=%0d occ=%h key=%h n=%0d sum=%h",
                             got.status, got.found, got.occurrences, got.key_out,
                             got.distinct_entries, got.total_items);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.occurrences !== want.occurrences || got.key_out !== want.key_out ||
                    got.distinct_entries !== want.distinct_entries ||
                    got.total_items !== want.total_items) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on word %0d", results_seen);
                        $display("  exp: st=%0d f=%0d occ=%h key=%h n=%0d sum=%h",
                                 want.status, want.found, want.occurrences, want.key_out,
                                 want.distinct_entries, want.total_items);
                        $display("  got: st=%0d f=%0d occ=%h key=%h n=%0d sum=%h",
                                 got.status, got.found, got.occurrences, got.key_out,
                                 got.distinct_entries, got.total_items);
                    end
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off to back the block up
    initial begin
        int rate;
        int cyc;
        rate = 0;
        cyc  = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cyc % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: rate = 0;
                    1: rate = 4;
                    default: rate = 15;
                endcase
            end
            cyc++;
            if (!calm && !held && results_seen >= 40) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!calm && rate != 0 && $urandom_range(0, rate) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (i_rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("counted_key_table test failed");
        $finish;
    end

    initial begin
        int i;
        int k;
        for (i = 0; i < POOL_WIDE; i++) key_pool[i] = $urandom;

        // empty table, then a small table built and partly torn down by hand
        add_row(OP_COUNT,     32'h0000_0000, 8'd0,   1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
        add_row(OP_GET,       32'h0000_0000, 8'd0,   1, ST_BAD_POS,   0, 0, 0, 0, 0);
        add_row(OP_ERASE_ONE, 32'hFFFF_FFFF, 8'd0,   1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
        add_row(OP_ERASE_ALL, 32'h0000_0000, 8'd0,   1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
        add_row(OP_RSVD_C,    32'hFFFF_FFFF, 8'hFF,  1, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_INSERT,    32'h0000_0000, 8'd0,   1, ST_OK,        0, 1, 0, 1, 1);
        add_row(OP_INSERT,    32'hFFFF_FFFF, 8'd0,   1, ST_OK,        0, 1, 0, 2, 2);
        add_row(OP_INSERT,    32'hFFFF_FFFF, 8'd0,   1, ST_OK,        1, 2, 0, 2, 3);
        add_row(OP_INSERT,    32'h5555_AAAA, 8'd0,   1, ST_OK,        0, 1, 0, 3, 4);
        add_row(OP_INSERT,    32'hAAAA_5555, 8'd0,   1, ST_OK,        0, 1, 0, 4, 5);
        add_row(OP_GET,       32'h0000_0000, 8'd0,   1, ST_OK,        1, 1, 0, 4, 5);
        add_row(OP_GET,       32'h0000_0000, 8'd1,   1, ST_OK,        1, 2, 32'hFFFF_FFFF, 4, 5);
        add_row(OP_GET,       32'h0000_0000, 8'd255, 1, ST_BAD_POS,   0, 0, 0, 4, 5);
        add_row(OP_GET,       32'h0000_0000, 8'd4,   1, ST_BAD_POS,   0, 0, 0, 4, 5);
        add_row(OP_COUNT,     32'hFFFF_FFFF, 8'd0,   1, ST_OK,        1, 2, 0, 4, 5);
        add_row(OP_ERASE_ONE, 32'hFFFF_FFFF, 8'd0,   1, ST_OK,        1, 1, 0, 4, 4);
        add_row(OP_ERASE_ONE, 32'h0000_0000, 8'd0,   1, ST_OK,        1, 1, 0, 3, 3);
        add_row(OP_GET,       32'h0000_0000, 8'd0,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_RSVD_A,    32'h1234_5678, 8'd1,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_RSVD_B,    32'h5555_AAAA, 8'd2,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_INSERT,    32'hAAAA_5555, 8'd0,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_ERASE_ALL, 32'hAAAA_5555, 8'd0,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_ERASE_ALL, 32'hFFFF_FFFF, 8'd0,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_COUNT,     32'h1234_5678, 8'd0,   0, ST_OK,        0, 0, 0, 0, 0);
        add_row(OP_GET,       32'h0000_0000, 8'd0,   0, ST_OK,        0, 0, 0, 0, 0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < rows.size(); i++)
            send_word(rows[i].op, rows[i].key, rows[i].pos, rows[i].typed, rows[i].res);

        // few keys, so counts climb and entries come and go
        for (i = 0; i < 500; i++) random_word(POOL_NARROW);

        // fill to capacity, then work on a full table
        while (tbl_used < CAPACITY) begin
            if ($urandom_range(0, 9) == 0) random_word(POOL_WIDE);
            else send_word(OP_INSERT, $urandom, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        for (i = 0; i < 120; i++) random_word(POOL_WIDE);

        // drain by erasing keys that are present
        while (tbl_used > 0) begin
            k = $urandom_range(0, 9);
            if (k < 3)      send_word(OP_ERASE_ONE, tbl_keys[$urandom_range(0, tbl_used - 1)],
                                      8'd0, 1'b0, '0);
            else if (k < 8) send_word(OP_ERASE_ALL, tbl_keys[$urandom_range(0, tbl_used - 1)],
                                      8'd0, 1'b0, '0);
            else            random_word(POOL_WIDE);
        end

        for (i = 0; i < 250; i++) random_word(POOL_WIDE);
        calm = 1'b1;
        for (i = 0; i < 200; i++) random_word(POOL_WIDE);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("counted_key_table test passed");
        else
            $display("counted_key_table test failed");
        $finish;
    end

endmodule

>>> counted_key_table.f
hw/rtl/ckt_pkg.sv
hw/rtl/ckt_ram.sv
hw/rtl/ckt_engine.sv
hw/rtl/counted_key_table.sv
bench/tb.sv
